FILE: src/iccm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccm_pkg
// Shared constants and fixed-point helpers for the iteration count color
// mapper.
// ----------------------------------------------------------------------------
package iccm_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 16;

	// Fractions carry one extra integer bit so that 1.0 fits.
	localparam int FX_W = FRAC_BITS + 1;

	// Channel scale factors fit in 13 bits; the widest operand is A + t.
	localparam int KW = 13;
	localparam int XW = FRAC_BITS + 1;
	localparam int PW = KW + XW;

	// Two quotient bits are resolved in each divider stage.
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

	// Register indexes of the configuration port.
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_PALETTE   = 1'b1;

	localparam int DATA_W = COUNT_BITS;

	// Palette codes; the fourth code wraps around to the first palette.
	localparam logic [1:0] PAL_WARM = 2'd0;
	localparam logic [1:0] PAL_SWAP = 2'd1;
	localparam logic [1:0] PAL_RAMP = 2'd2;

	localparam logic [KW-1:0] K_A     = KW'(2295);
	localparam logic [KW-1:0] K_B     = KW'(3825);
	localparam logic [KW-1:0] K_C     = KW'(4335);
	localparam logic [KW-1:0] K_RAMP  = KW'(255);
	localparam logic [KW-1:0] K_RAMPG = KW'(150);
	localparam logic [KW-1:0] K_RAMPB = KW'(40);

	localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;

	// Truncated product of two fractions.
	function automatic logic [FX_W-1:0] fx_mul(input logic [FX_W-1:0] a,
	                                           input logic [FX_W-1:0] b);
		logic [2*FX_W-1:0] p;
		p = {{FX_W{1'b0}}, a} * {{FX_W{1'b0}}, b};
		return p[FRAC_BITS +: FX_W];
	endfunction

	// floor(k * x / 2^(FRAC_BITS + extra)), saturated to 255.
	function automatic logic [7:0] chan(input logic [KW-1:0] k,
	                                    input logic [XW-1:0] x,
	                                    input logic extra);
		logic [PW-1:0] p;
		logic [PW-1:0] v;
		p = PW'(k) * PW'(x);
		v = extra ? (p >> (FRAC_BITS + 1)) : (p >> FRAC_BITS);
		return (v > PW'(255)) ? 8'hFF : v[7:0];
	endfunction

endpackage

FILE: src/iteration_count_color_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iteration_count_color_mapper_top
// Maps an escape iteration count to an RGB pixel through one of three
// polynomial palettes.
// ----------------------------------------------------------------------------
// The pipeline has one input stage, eight divider stages at two quotient
// bits each, three multiplier stages and one channel scaling stage that is
// the output. Throughput: one item per cycle while the output is not
// stalled; each stage holds when the one after it is full and stalled, so
// bubbles are squeezed out.
// Reset clears all valid bits and loads the limit with 100 and palette 0.
module iteration_count_color_mapper_top
	import iccm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0]     wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COUNT_BITS-1:0] iteration_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue
);

	localparam int S_M1  = DIV_STAGES + 1;
	localparam int S_M2  = DIV_STAGES + 2;
	localparam int S_M3  = DIV_STAGES + 3;
	localparam int S_OUT = DIV_STAGES + 4;
	localparam int NSTG  = DIV_STAGES + 5;

	logic [COUNT_BITS-1:0] max_count_q;
	logic [1:0]            palette_q;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] ld;

	// Divider stages; entry zero is the input stage.
	logic [COUNT_BITS-1:0] rem_sd [0:DIV_STAGES];
	logic [FRAC_BITS-1:0]  q_sd   [0:DIV_STAGES];
	logic                  blk_sd [0:DIV_STAGES];
	logic [COUNT_BITS-1:0] rem_nx [1:DIV_STAGES];
	logic [FRAC_BITS-1:0]  q_nx   [1:DIV_STAGES];

	logic [FX_W-1:0] t_sm1, u_sm1, t2_sm1, ut_sm1;
	logic            blk_sm1;
	logic [FX_W-1:0] t_sm2, u_sm2, t3_sm2, b_sm2, d_sm2;
	logic            blk_sm2;
	logic [FX_W-1:0] t_sm3, a_sm3, b_sm3, c_sm3, d_sm3;
	logic            blk_sm3;
	logic [7:0]      red_so, green_so, blue_so;

	logic [FX_W-1:0] t_m1, u_m1;
	logic [XW-1:0]   a_x, b_x, c_x, d_x, at_x;
	logic [7:0]      red_nx, green_nx, blue_nx;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= COUNT_BITS'(100);
			palette_q   <= PAL_WARM;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_COUNT: max_count_q <= wr_data[COUNT_BITS-1:0];
				REG_PALETTE:   palette_q   <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it moves.
	always_comb begin
		ld[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	assign in_stall = !ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (ld[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Restoring division, count * 2^FRAC_BITS / max, two bits per stage.
	always_comb begin
		logic [COUNT_BITS:0]   tmp;
		logic [COUNT_BITS-1:0] r;
		logic [FRAC_BITS-1:0]  q;
		for (int k = 1; k <= DIV_STAGES; k++) begin
			r = rem_sd[k-1];
			q = q_sd[k-1];
			for (int j = 0; j < DIV_STEPS; j++) begin
				if ((k - 1) * DIV_STEPS + j < FRAC_BITS) begin
					tmp = {r, 1'b0};
					if (tmp >= {1'b0, max_count_q}) begin
						tmp = tmp - {1'b0, max_count_q};
						q   = {q[FRAC_BITS-2:0], 1'b1};
					end else begin
						q   = {q[FRAC_BITS-2:0], 1'b0};
					end
					r = tmp[COUNT_BITS-1:0];
				end
			end
			rem_nx[k] = r;
			q_nx[k]   = q;
		end
	end

	assign t_m1 = {1'b0, q_sd[DIV_STAGES]};
	assign u_m1 = ONE_FX - t_m1;

	assign a_x  = XW'(a_sm3);
	assign b_x  = XW'(b_sm3);
	assign c_x  = XW'(c_sm3);
	assign d_x  = XW'(d_sm3);
	assign at_x = XW'(a_sm3) + XW'(t_sm3);

	always_comb begin
		case (palette_q)
			PAL_SWAP: begin
				red_nx   = chan(K_B, b_x, 1'b0);
				green_nx = chan(K_A, a_x, 1'b0);
				blue_nx  = chan(K_C, c_x, 1'b1);
			end
			PAL_RAMP: begin
				red_nx   = chan(K_RAMP, at_x, 1'b0);
				green_nx = chan(K_RAMPG, b_x, 1'b0);
				blue_nx  = chan(K_RAMPB, d_x, 1'b0);
			end
			default: begin
				red_nx   = chan(K_A, a_x, 1'b0);
				green_nx = chan(K_B, b_x, 1'b0);
				blue_nx  = chan(K_C, c_x, 1'b1);
			end
		endcase
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			rem_sd[0] <= iteration_count;
			q_sd[0]   <= '0;
			blk_sd[0] <= (iteration_count >= max_count_q);
		end
		for (int k = 1; k <= DIV_STAGES; k++) begin
			if (ld[k]) begin
				rem_sd[k] <= rem_nx[k];
				q_sd[k]   <= q_nx[k];
				blk_sd[k] <= blk_sd[k-1];
			end
		end
		if (ld[S_M1]) begin
			t_sm1   <= t_m1;
			u_sm1   <= u_m1;
			t2_sm1  <= fx_mul(t_m1, t_m1);
			ut_sm1  <= fx_mul(u_m1, t_m1);
			blk_sm1 <= blk_sd[DIV_STAGES];
		end
		if (ld[S_M2]) begin
			t_sm2   <= t_sm1;
			u_sm2   <= u_sm1;
			t3_sm2  <= fx_mul(t2_sm1, t_sm1);
			b_sm2   <= fx_mul(ut_sm1, ut_sm1);
			d_sm2   <= fx_mul(ut_sm1, u_sm1);
			blk_sm2 <= blk_sm1;
		end
		if (ld[S_M3]) begin
			t_sm3   <= t_sm2;
			a_sm3   <= fx_mul(t3_sm2, u_sm2);
			b_sm3   <= b_sm2;
			c_sm3   <= fx_mul(d_sm2, u_sm2);
			d_sm3   <= d_sm2;
			blk_sm3 <= blk_sm2;
		end
		if (ld[S_OUT]) begin
			// A count at or above the limit is inside the set: black.
			red_so   <= blk_sm3 ? 8'h00 : red_nx;
			green_so <= blk_sm3 ? 8'h00 : green_nx;
			blue_so  <= blk_sm3 ? 8'h00 : blue_nx;
		end
	end

	assign out_valid = vld_q[S_OUT];
	assign red       = red_so;
	assign green     = green_so;
	assign blue      = blue_so;

	// The input side only waits while the first stage holds an item.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_q[0])
		else $error("input stalled with an empty first stage");

	// A free output lets the whole pipeline advance.
	a_free_output_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while the output was free");

	// An item moving into the output stage shows up as a valid result.
	a_item_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[S_M3] && ld[S_OUT]) |=> out_valid)
		else $error("item lost on its way to the output");

endmodule

FILE: tb/iccm_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iccm_pixel_checker
// Watches the register port and both item channels of the color mapper. It
// keeps its own copy of the limit and the palette, works out the pixel for
// every accepted count and compares each accepted pixel with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module iccm_pixel_checker
	import iccm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [DATA_W-1:0]     wr_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [COUNT_BITS-1:0] iteration_count,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output int                    pending_count,
	output int                    mismatch_count
);

	localparam logic [12:0] GAIN_CUBIC   = 13'd2295;
	localparam logic [12:0] GAIN_SQUARE  = 13'd3825;
	localparam logic [12:0] GAIN_BLUE_X2 = 13'd4335;
	localparam logic [12:0] GAIN_RAMP_R  = 13'd255;
	localparam logic [12:0] GAIN_RAMP_G  = 13'd150;
	localparam logic [12:0] GAIN_RAMP_B  = 13'd40;

	// One integer bit above the fraction bits so that 1.0 is representable.
	typedef logic [FRAC_BITS:0] frac_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [7:0]            red;
		logic [7:0]            green;
		logic [7:0]            blue;
	} pixel_t;

	pixel_t                expected_pixels[$];
	pixel_t                owed;
	logic [COUNT_BITS-1:0] limit_reg;
	logic [1:0]            palette_reg;

	initial mismatch_count = 0;

	function automatic frac_t frac_product(input frac_t a, input frac_t b);
		logic [2*FRAC_BITS+1:0] p;
		p = a * b;
		return p[FRAC_BITS +: FRAC_BITS+1];
	endfunction

	function automatic logic [7:0] scale_channel(input logic [12:0] gain, input frac_t x,
	                                             input int extra);
		logic [29:0] p;
		logic [29:0] v;
		p = gain * x;
		v = p >> (FRAC_BITS + extra);
		return (v > 30'd255) ? 8'hFF : v[7:0];
	endfunction

	// Long division of count by limit, one quotient bit per step.
	function automatic frac_t count_ratio(input logic [COUNT_BITS-1:0] cnt,
	                                      input logic [COUNT_BITS-1:0] limit);
		logic [COUNT_BITS:0] rem;
		frac_t               q;
		int                  i;
		rem = {1'b0, cnt};
		q   = '0;
		for (i = 0; i < FRAC_BITS; i++) begin
			rem = {rem[COUNT_BITS-1:0], 1'b0};
			q   = q << 1;
			if (rem >= {1'b0, limit}) begin
				rem  = rem - {1'b0, limit};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic pixel_t predict_pixel(input logic [COUNT_BITS-1:0] cnt,
	                                         input logic [COUNT_BITS-1:0] limit,
	                                         input logic [1:0] palette);
		frac_t  t, u, t2, t3, a, ut, b, d, c;
		pixel_t px;
		px       = '0;
		px.count = cnt;
		// Inside the set, beyond the limit, or a limit of zero: black.
		if (cnt >= limit)
			return px;
		t  = count_ratio(cnt, limit);
		u  = (frac_t'(1) << FRAC_BITS) - t;
		t2 = frac_product(t, t);
		t3 = frac_product(t2, t);
		a  = frac_product(t3, u);
		ut = frac_product(u, t);
		b  = frac_product(ut, ut);
		d  = frac_product(ut, u);
		c  = frac_product(d, u);
		case (palette)
			PAL_SWAP: begin
				px.red   = scale_channel(GAIN_SQUARE, b, 0);
				px.green = scale_channel(GAIN_CUBIC, a, 0);
				px.blue  = scale_channel(GAIN_BLUE_X2, c, 1);
			end
			PAL_RAMP: begin
				px.red   = scale_channel(GAIN_RAMP_R, a + t, 0);
				px.green = scale_channel(GAIN_RAMP_G, b, 0);
				px.blue  = scale_channel(GAIN_RAMP_B, d, 0);
			end
			default: begin
				// The unused fourth code wraps around to the warm palette.
				px.red   = scale_channel(GAIN_CUBIC, a, 0);
				px.green = scale_channel(GAIN_SQUARE, b, 0);
				px.blue  = scale_channel(GAIN_BLUE_X2, c, 1);
			end
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic check_channel(input string name, input logic [COUNT_BITS-1:0] cnt,
	                             input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("count %0d: %s is %0d, expected %0d",
			                          cnt, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_reg     <= 16'd100;
			palette_reg   <= PAL_WARM;
			pending_count <= 0;
			expected_pixels.delete();
		end else begin
			// Results are retired before new counts are queued, so a pixel that
			// shows up with nothing owed cannot hide behind a fresh count.
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel %0d/%0d/%0d with nothing owed",
					                          red, green, blue));
				end else begin
					owed = expected_pixels.pop_front();
					check_channel("red", owed.count, red, owed.red);
					check_channel("green", owed.count, green, owed.green);
					check_channel("blue", owed.count, blue, owed.blue);
				end
			end
			if (in_valid && !in_stall)
				expected_pixels.push_back(predict_pixel(iteration_count, limit_reg,
				                                        palette_reg));
			if (wr_en) begin
				if (wr_index == REG_MAX_COUNT)
					limit_reg <= wr_data[COUNT_BITS-1:0];
				else if (wr_index == REG_PALETTE)
					palette_reg <= wr_data[1:0];
			end
			pending_count <= expected_pixels.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the iteration count color mapper. A directed pass covers
// the reset settings, limits of zero, one and full scale, every palette code
// and counts at, below and above the limit. Random phases then vary the
// limit and palette while the sender and the receiver idle at different
// rates, and one phase holds the output off long enough to back the pipeline
// up into its input. A separate checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb;
	import iccm_pkg::*;

	localparam int         CYCLE_LIMIT = 500000;
	localparam int         HOLD_CYCLES = 80;
	localparam int         TAIL_CYCLES = 40;
	localparam logic [1:0] PAL_WRAP    = 2'd3;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  wr_en           = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index        = REG_MAX_COUNT;
	logic [DATA_W-1:0]     wr_data         = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [COUNT_BITS-1:0] iteration_count = '0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;

	int                    pending_count;
	int                    mismatch_count;
	int                    cycle_count     = 0;
	int                    gap_pct         = 0;
	int                    stall_pct       = 0;
	bit                    hold_armed      = 1'b0;
	logic [COUNT_BITS-1:0] probes[$];

	iteration_count_color_mapper_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.iteration_count (iteration_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.red             (red),
		.green           (green),
		.blue            (blue)
	);

	iccm_pixel_checker pixel_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.iteration_count (iteration_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.pending_count   (pending_count),
		.mismatch_count  (mismatch_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off when a phase arms it.
	initial begin
		int held;
		forever begin
			@(posedge clk);
			if (hold_armed) begin
				held = 0;
				while (held < HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
					held++;
				end
				hold_armed = 1'b0;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic logic [COUNT_BITS-1:0] pick_count(input logic [COUNT_BITS-1:0] limit);
		int sel;
		sel = $urandom_range(0, 99);
		if (limit != 0 && sel < 70)
			return COUNT_BITS'($urandom_range(0, int'(limit) - 1));
		if (sel < 80)
			return limit;
		return COUNT_BITS'($urandom);
	endfunction

	// Returns right after the edge at which the item was taken.
	task automatic send_pixel(input logic [COUNT_BITS-1:0] cnt);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		iteration_count <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_probes();
		foreach (probes[i])
			send_pixel(probes[i]);
	endtask

	// The extra edge lets the checker's count catch up with the last item.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic reconfigure(input logic [COUNT_BITS-1:0] limit, input logic [1:0] palette);
		wait_for_idle();
		wr_en    <= 1'b1;
		wr_index <= REG_MAX_COUNT;
		wr_data  <= limit;
		@(posedge clk);
		// Upper bits of the palette word are junk that the block must ignore.
		wr_index <= REG_PALETTE;
		wr_data  <= {(DATA_W-2)'($urandom), palette};
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random_phase(input logic [COUNT_BITS-1:0] limit,
	                                input logic [1:0] palette, input int n_items,
	                                input int gap, input int stall, input bit pressure);
		int k;
		reconfigure(limit, palette);
		gap_pct   = gap;
		stall_pct = stall;
		if (pressure)
			hold_armed = 1'b1;
		for (k = 0; k < n_items; k++)
			send_pixel(pick_count(limit));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: limit of 100 with the warm palette.
		probes = '{16'd0, 16'd1, 16'd2, 16'd50, 16'd98, 16'd99, 16'd100, 16'd101,
		           16'hFFFF, 16'hAAAA, 16'h5555};
		send_probes();
		reconfigure(16'hFFFF, PAL_SWAP);
		probes = '{16'd0, 16'd1, 16'h8000, 16'hFFFE, 16'hFFFF};
		send_probes();
		reconfigure(16'd1, PAL_RAMP);
		probes = '{16'd0, 16'd1, 16'd2};
		send_probes();
		// A limit of zero turns every count black.
		reconfigure(16'd0, PAL_WRAP);
		probes = '{16'd0, 16'd7};
		send_probes();
		reconfigure(16'd3, PAL_WRAP);
		probes = '{16'd0, 16'd1, 16'd2, 16'd3};
		send_probes();

		run_random_phase(16'hFFFF, PAL_SWAP, 170, 0, 0, 1'b0);
		run_random_phase(16'd1, PAL_RAMP, 100, 82, 0, 1'b0);
		run_random_phase(COUNT_BITS'($urandom_range(2, 1000)), PAL_WRAP, 170, 0, 82, 1'b0);
		run_random_phase(16'd0, PAL_WARM, 60, 18, 18, 1'b0);
		run_random_phase(16'd255, PAL_RAMP, 200, 0, 0, 1'b1);
		run_random_phase(COUNT_BITS'($urandom_range(1, 65535)), PAL_SWAP, 170, 82, 0, 1'b0);
		run_random_phase(COUNT_BITS'($urandom_range(2, 300)), PAL_WARM, 170, 0, 82, 1'b0);
		run_random_phase(16'hFFFF, PAL_RAMP, 170, 18, 18, 1'b0);
		run_random_phase(COUNT_BITS'($urandom_range(2, 5000)), PAL_WARM, 170, 0, 0, 1'b0);

		wait_for_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/iccm_pkg.sv
src/iteration_count_color_mapper_top.sv
tb/iccm_pixel_checker.sv
tb/tb.sv
